>>> rtl/core/bthf_pkg.sv
// Shared types, constants and helpers for the boundary-tag heap free block.
// Used by bthf_ctrl, boundary_tag_heap_free and the testbench; depends on nothing else.
package bthf_pkg;

  // Heap geometry. HEAP_WORDS must be a power of two; word indexes wrap by truncation.
  localparam int HEAP_WORDS = 1024;
  localparam int IDX_W      = $clog2(HEAP_WORDS);
  localparam int WORD_W     = 32;
  localparam int ADDR_W     = 12;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [WORD_W-1:0] word_t;

  // Action codes of an input item.
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_FREE  = 2'd2;

  // Status codes of a result item.
  localparam logic [1:0] STAT_DONE     = 2'd0;
  localparam logic [1:0] STAT_NULL     = 2'd1;
  localparam logic [1:0] STAT_MISALIGN = 2'd2;

  // Header bits and the end marker.
  localparam int    BUSY_BIT      = 0;
  localparam int    PREV_BUSY_BIT = 1;
  localparam word_t END_MARK      = 32'd1;

  // One heap memory access, issued by the sequencer.
  typedef struct packed {
    logic  we;
    idx_t  addr;
    word_t wdata;
  } mem_req_t;

  // One result item.
  typedef struct packed {
    word_t      read_data;
    logic [1:0] status;
  } result_t;

  // Word index named by a byte address.
  function automatic idx_t idx_of_addr(input logic [ADDR_W-1:0] addr);
    logic [31:0] a32;
    a32 = 32'(addr);
    return a32[IDX_W+1:2];
  endfunction

  // Size field of a header word (bits 2..0 cleared).
  function automatic word_t size_of(input word_t v);
    return {v[WORD_W-1:3], 3'b000};
  endfunction

  // Word distance of a header size, wrapped to the heap.
  function automatic idx_t hdr_words(input word_t v);
    logic [31:0] s;
    s = size_of(v);
    return s[IDX_W+1:2];
  endfunction

  // Word distance of a footer's byte count, wrapped to the heap.
  function automatic idx_t foot_words(input word_t v);
    return v[IDX_W+1:2];
  endfunction

endpackage

>>> rtl/core/boundary_tag_heap_free.sv
// Top level of the boundary-tag heap free block: heap RAM, sequencer and result register.
// Depends on bthf_pkg, bthf_ram and bthf_ctrl.
//
// Usage:
//   Input channel in_valid/in_ready carries one item: in_action, in_address,
//   in_write_data. Action write stores a heap word, read returns one, free
//   releases the block whose payload starts at in_address and coalesces it
//   with free neighbors. Each item yields exactly one result on the
//   out_valid/out_ready channel: out_read_data and out_status.
//   The single port of the heap RAM sets the pace: every read and write of
//   the free sequence takes its own turn on the port, and a read's data is
//   registered. A free with a free previous block needs more accesses than
//   one without, and a null or misaligned free touches no heap word.
//   One item is processed at a time; the next item is accepted once the
//   previous result sits in the output register, so a result waiting on a
//   stalled receiver does not block the following item's work. A second
//   finished result waits inside the sequencer until the register empties.
//   Synchronous active-low reset returns the sequencer to idle and empties
//   the output register; heap contents are undefined until written.
module boundary_tag_heap_free
  import bthf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_action,
  input  logic [ADDR_W-1:0] in_address,
  input  logic [31:0]       in_write_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       out_read_data,
  output logic [1:0]        out_status
);

  mem_req_t mem_req;
  word_t    mem_rdata;
  logic     res_valid;
  logic     res_take;
  result_t  res;

  logic     out_valid_r;
  result_t  out_r;

  // Heap word memory.
  bthf_ram #(
    .WIDTH(WORD_W),
    .DEPTH(HEAP_WORDS)
  ) u_ram (
    .clk  (clk),
    .we   (mem_req.we),
    .addr (mem_req.addr),
    .wdata(mem_req.wdata),
    .rdata(mem_rdata)
  );

  // Access and free sequencer.
  bthf_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_action    (in_action),
    .in_address   (in_address),
    .in_write_data(in_write_data),
    .mem_rdata    (mem_rdata),
    .mem_req      (mem_req),
    .res_valid    (res_valid),
    .res_take     (res_take),
    .res          (res)
  );

  // The output register takes a result when it is empty or being drained.
  assign res_take = res_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_r.read_data;
  assign out_status    = out_r.status;

endmodule

>>> rtl/core/bthf_ram.sv
// Generic single-port synchronous RAM with a registered read port.
// Standalone; no package dependency.
module bthf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write on demand; the read data is registered and appears in the cycle after the address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/bthf_ctrl.sv
// Sequencer for heap accesses and the boundary-tag free with coalescing.
// Depends on bthf_pkg; drives the single heap memory port.
module bthf_ctrl
  import bthf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_action,
  input  logic [ADDR_W-1:0]     in_address,
  input  word_t                 in_write_data,
  input  word_t                 mem_rdata,
  output mem_req_t              mem_req,
  output logic                  res_valid,
  input  logic                  res_take,
  output result_t               res
);

  // Sequencer state codes.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RDATA = 4'd1;
  localparam logic [3:0] S_HDR   = 4'd2;
  localparam logic [3:0] S_NRD   = 4'd3;
  localparam logic [3:0] S_NXT   = 4'd4;
  localparam logic [3:0] S_PLAN  = 4'd5;
  localparam logic [3:0] S_PFOOT = 4'd6;
  localparam logic [3:0] S_PRD   = 4'd7;
  localparam logic [3:0] S_PREV  = 4'd8;
  localparam logic [3:0] S_FOOT  = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0] state_r, state_nxt;
  idx_t       hdr_r, nxt_r, foot_r, prv_r;
  word_t      hc_r, nc_r, base_r, fval_r;
  result_t    res_r;

  logic  accept;
  idx_t  in_idx;
  word_t h_clr, n_cur, merged_hn, prev_sum;
  logic  prev_free, next_free;
  idx_t  foot_idx;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign in_idx    = idx_of_addr(in_address);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  // Values derived from the data just read.
  assign h_clr = mem_rdata & ~(word_t'(1) << BUSY_BIT);
  assign n_cur = (mem_rdata != END_MARK) ? (mem_rdata & ~(word_t'(1) << PREV_BUSY_BIT))
                                         : mem_rdata;

  // Merge decision on the current header and next-header values.
  assign prev_free = !hc_r[PREV_BUSY_BIT];
  assign next_free = !nc_r[BUSY_BIT];
  assign foot_idx  = next_free ? (nxt_r + hdr_words(nc_r) - idx_t'(1))
                               : (hdr_r + hdr_words(hc_r) - idx_t'(1));
  assign merged_hn = size_of(nc_r) + size_of(hc_r)
                     + (hc_r & (word_t'(1) << PREV_BUSY_BIT));
  assign prev_sum  = base_r + size_of(mem_rdata)
                     + (mem_rdata & (word_t'(1) << PREV_BUSY_BIT));

  // Next state and memory port.
  always_comb begin
    state_nxt     = state_r;
    mem_req.we    = 1'b0;
    mem_req.addr  = '0;
    mem_req.wdata = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_action)
            ACT_WRITE: begin
              mem_req.we    = 1'b1;
              mem_req.addr  = in_idx;
              mem_req.wdata = in_write_data;
              state_nxt     = S_DONE;
            end
            ACT_READ: begin
              mem_req.addr = in_idx;
              state_nxt    = S_RDATA;
            end
            ACT_FREE: begin
              if (in_address != '0 && in_address[2:0] == 3'b000) begin
                mem_req.addr = in_idx - idx_t'(1);
                state_nxt    = S_HDR;
              end else begin
                state_nxt = S_DONE;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_RDATA: state_nxt = S_DONE;
      S_HDR: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = hdr_r;
        mem_req.wdata = h_clr;
        state_nxt     = S_NRD;
      end
      S_NRD: begin
        mem_req.addr = nxt_r;
        state_nxt    = S_NXT;
      end
      S_NXT: begin
        mem_req.we    = (mem_rdata != END_MARK);
        mem_req.addr  = nxt_r;
        mem_req.wdata = n_cur;
        state_nxt     = S_PLAN;
      end
      S_PLAN: begin
        if (prev_free) begin
          mem_req.addr = hdr_r - idx_t'(1);
          state_nxt    = S_PFOOT;
        end else if (next_free) begin
          mem_req.we    = 1'b1;
          mem_req.addr  = hdr_r;
          mem_req.wdata = merged_hn;
          state_nxt     = S_FOOT;
        end else begin
          state_nxt = S_FOOT;
        end
      end
      S_PFOOT: state_nxt = S_PRD;
      S_PRD: begin
        mem_req.addr = prv_r;
        state_nxt    = S_PREV;
      end
      S_PREV: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = prv_r;
        mem_req.wdata = prev_sum;
        state_nxt     = S_FOOT;
      end
      S_FOOT: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = foot_r;
        mem_req.wdata = fval_r;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Working registers of the free sequence and the result.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        hdr_r           <= in_idx - idx_t'(1);
        res_r.read_data <= '0;
        if (in_action == ACT_FREE && in_address == '0) begin
          res_r.status <= STAT_NULL;
        end else if (in_action == ACT_FREE && in_address[2:0] != 3'b000) begin
          res_r.status <= STAT_MISALIGN;
        end else begin
          res_r.status <= STAT_DONE;
        end
      end
      S_RDATA: res_r.read_data <= mem_rdata;
      S_HDR: begin
        hc_r  <= h_clr;
        nxt_r <= hdr_r + hdr_words(h_clr);
      end
      S_NXT: begin
        nc_r <= n_cur;
        // The next header may be this very header when the size is a multiple of the heap size, zero included.
        if (nxt_r == hdr_r) begin
          hc_r <= n_cur;
        end
      end
      S_PLAN: begin
        foot_r <= foot_idx;
        base_r <= (next_free ? size_of(nc_r) : '0) + size_of(hc_r);
        fval_r <= next_free ? size_of(merged_hn) : size_of(hc_r);
      end
      S_PFOOT: prv_r  <= hdr_r - foot_words(mem_rdata);
      S_PREV:  fval_r <= size_of(prev_sum);
      default: ;
    endcase
  end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for boundary_tag_heap_free: a directed heap layout, then random heap
// runs and noise items, each result checked against an in-bench model of the heap words.
// Depends on bthf_pkg and the boundary_tag_heap_free RTL.
module testbench;
  import bthf_pkg::*;

  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam word_t BUSY_M = word_t'(1) << BUSY_BIT;
  localparam word_t PREV_M = word_t'(1) << PREV_BUSY_BIT;
  localparam word_t SIZE_M = ~word_t'(7);
  localparam int ITEM_TARGET = 950;
  localparam int DIRECTED_ROWS = 25;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam int TAIL_CYCLES = 12;

  // One row of the directed table; want is used only where typed is set.
  typedef struct packed {
    logic [1:0]        act;
    logic [ADDR_W-1:0] addr;
    word_t             data;
    bit                typed;
    result_t           want;
  } plan_row_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_action;
  logic [ADDR_W-1:0] in_address;
  word_t             in_write_data;
  logic              out_valid;
  logic              out_ready = 1'b0;
  word_t             out_read_data;
  logic [1:0]        out_status;

  // Heap image kept by the bench, with a mark for every word written so far.
  word_t   heap_img [HEAP_WORDS];
  bit      heap_set [HEAP_WORDS];
  word_t   heap_bak [HEAP_WORDS];
  bit      set_bak [HEAP_WORDS];
  bit      miss_flag = 1'b0;
  idx_t    miss_idx;
  result_t pending_results [$];

  int items_sent = 0;
  int mismatches = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int idle_by_phase [4] = '{0, 45, 0, 38};
  int stall_by_phase [4] = '{0, 0, 45, 38};

  // Directed table: lays out three busy blocks, frees them into one, then covers the
  // error codes, the unused action, wraparound and a merge with the previous block only.
  plan_row_t plan [DIRECTED_ROWS] = '{
    '{ACT_WRITE, 12'h004, 32'h0000_0013, 1'b0, '0},
    '{ACT_WRITE, 12'h014, 32'h0000_0013, 1'b0, '0},
    '{ACT_WRITE, 12'h024, 32'h0000_0013, 1'b0, '0},
    '{ACT_WRITE, 12'h034, 32'h0000_0001, 1'b0, '0},
    '{ACT_READ,  12'h017, 32'h0000_0000, 1'b1, '{32'h0000_0013, STAT_DONE}},
    '{ACT_FREE,  12'h008, 32'h0000_0000, 1'b0, '0},
    '{ACT_FREE,  12'h028, 32'h0000_0000, 1'b0, '0},
    '{ACT_FREE,  12'h018, 32'h0000_0000, 1'b0, '0},
    '{ACT_READ,  12'h004, 32'h0000_0000, 1'b0, '0},
    '{ACT_FREE,  12'h008, 32'h0000_0000, 1'b0, '0},
    '{ACT_FREE,  12'h000, 32'hFFFF_FFFF, 1'b1, '{32'h0, STAT_NULL}},
    '{ACT_FREE,  12'h004, 32'h0000_0000, 1'b1, '{32'h0, STAT_MISALIGN}},
    '{ACT_FREE,  12'hFFC, 32'h0000_0000, 1'b1, '{32'h0, STAT_MISALIGN}},
    '{ACT_NONE,  12'hFFF, 32'hFFFF_FFFF, 1'b1, '{32'h0, STAT_DONE}},
    '{ACT_WRITE, 12'hFFF, 32'hFFFF_FFFF, 1'b0, '0},
    '{ACT_READ,  12'hFFC, 32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, STAT_DONE}},
    '{ACT_WRITE, 12'hFF4, 32'h0000_0023, 1'b0, '0},
    '{ACT_FREE,  12'hFF8, 32'h0000_0000, 1'b0, '0},
    '{ACT_READ,  12'hFF4, 32'h0000_0000, 1'b0, '0},
    '{ACT_WRITE, 12'h04C, 32'h0000_000A, 1'b0, '0},
    '{ACT_WRITE, 12'h050, 32'h0000_000B, 1'b0, '0},
    '{ACT_WRITE, 12'h054, 32'h0000_0011, 1'b0, '0},
    '{ACT_WRITE, 12'h064, 32'h0000_0001, 1'b0, '0},
    '{ACT_FREE,  12'h058, 32'h0000_0000, 1'b0, '0},
    '{ACT_READ,  12'h04C, 32'h0000_0000, 1'b0, '0}
  };

  always #4 clk = ~clk;

  boundary_tag_heap_free dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_action    (in_action),
    .in_address   (in_address),
    .in_write_data(in_write_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_read_data(out_read_data),
    .out_status   (out_status)
  );

  // Reads a heap word and notes the first word read before it was ever written.
  function automatic word_t heap_peek(idx_t i);
    if (!heap_set[i] && !miss_flag) begin
      miss_flag = 1'b1;
      miss_idx = i;
    end
    return heap_img[i];
  endfunction

  function automatic void heap_poke(idx_t i, word_t v);
    heap_img[i] = v;
    heap_set[i] = 1'b1;
  endfunction

  function automatic idx_t words_in(word_t bytes);
    return idx_t'(bytes >> 2);
  endfunction

  function automatic word_t block_bytes(idx_t i);
    return heap_peek(i) & SIZE_M;
  endfunction

  function automatic idx_t last_word(idx_t hdr);
    return idx_t'(hdr + words_in(block_bytes(hdr)) - idx_t'(1));
  endfunction

  // Frees the block whose payload starts at addr and merges it with free neighbors.
  function automatic void release_block(logic [ADDR_W-1:0] addr);
    idx_t  hdr;
    idx_t  nxt;
    idx_t  prv;
    idx_t  foot;
    bit    next_free;
    bit    prev_free;
    word_t merged;
    hdr = idx_t'(idx_t'(addr >> 2) - idx_t'(1));
    heap_poke(hdr, heap_peek(hdr) & ~BUSY_M);
    nxt = idx_t'(hdr + words_in(block_bytes(hdr)));
    // The end marker keeps its value and counts as busy.
    if (heap_peek(nxt) != END_MARK) heap_poke(nxt, heap_peek(nxt) & ~PREV_M);
    next_free = (heap_peek(nxt) & BUSY_M) == word_t'(0);
    prev_free = (heap_peek(hdr) & PREV_M) == word_t'(0);
    if (prev_free) begin
      prv = idx_t'(hdr - words_in(heap_peek(idx_t'(hdr - idx_t'(1)))));
      foot = next_free ? last_word(nxt) : last_word(hdr);
      merged = (next_free ? block_bytes(nxt) : word_t'(0)) + block_bytes(hdr)
               + block_bytes(prv) + (heap_peek(prv) & PREV_M);
      heap_poke(prv, merged);
      heap_poke(foot, block_bytes(prv));
    end else if (next_free) begin
      foot = last_word(nxt);
      heap_poke(hdr, block_bytes(nxt) + block_bytes(hdr) + (heap_peek(hdr) & PREV_M));
      heap_poke(foot, block_bytes(hdr));
    end else begin
      heap_poke(last_word(hdr), block_bytes(hdr));
    end
  endfunction

  // Applies one item to the heap image and returns the result it should produce.
  function automatic result_t heap_result(logic [1:0] act, logic [ADDR_W-1:0] addr,
                                          word_t data);
    result_t r;
    r.read_data = '0;
    r.status = STAT_DONE;
    case (act)
      ACT_WRITE: heap_poke(idx_t'(addr >> 2), data);
      ACT_READ: r.read_data = heap_peek(idx_t'(addr >> 2));
      ACT_FREE: begin
        if (addr == '0) r.status = STAT_NULL;
        else if (addr[2:0] != 3'b000) r.status = STAT_MISALIGN;
        else release_block(addr);
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] word_addr(idx_t i);
    return {i, 2'($urandom_range(3))};
  endfunction

  function automatic logic [ADDR_W-1:0] payload_addr(idx_t hdr);
    return {idx_t'(hdr + idx_t'(1)), 2'b00};
  endfunction

  // Records the expected result, then offers the item until the block takes it.
  task automatic send_item(logic [1:0] act, logic [ADDR_W-1:0] addr, word_t data,
                           bit typed = 1'b0, result_t typed_res = '0);
    result_t r;
    r = heap_result(act, addr, data);
    pending_results.push_back(typed ? typed_res : r);
    items_sent++;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_address <= addr;
    in_write_data <= data;
    do @(posedge clk); while (!in_ready);
  endtask

  // Makes sure the item reads only written words: a read gets its word written first,
  // and a free is tried on a copy of the heap until every word it reads is known.
  task automatic issue(logic [1:0] act, logic [ADDR_W-1:0] addr, word_t data,
                       bit typed = 1'b0, result_t typed_res = '0);
    if (act == ACT_READ && !heap_set[idx_t'(addr >> 2)])
      send_item(ACT_WRITE, addr, $urandom());
    if (act == ACT_FREE && addr != '0 && addr[2:0] == 3'b000) begin
      forever begin
        heap_bak = heap_img;
        set_bak = heap_set;
        miss_flag = 1'b0;
        release_block(addr);
        heap_img = heap_bak;
        heap_set = set_bak;
        if (!miss_flag) break;
        send_item(ACT_WRITE, {miss_idx, 2'($urandom_range(3))}, $urandom());
      end
    end
    send_item(act, addr, data, typed, typed_res);
  endtask

  // Stops offering items until every expected result has come back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Lays out a free block, a run of busy blocks and a closing block, then frees the run
  // in random order, now and then freeing a block twice or reading a header back.
  task automatic heap_episode();
    idx_t  base;
    idx_t  cur;
    idx_t  hdrs [6];
    int    order [6];
    int    nblk;
    int    k;
    int    j;
    int    tmp;
    word_t sz;
    nblk = $urandom_range(2, 6);
    base = idx_t'(2 * $urandom_range(0, HEAP_WORDS / 2 - 1) + 1);
    sz = word_t'(8 * $urandom_range(1, 4));
    issue(ACT_WRITE, word_addr(base), sz | PREV_M);
    issue(ACT_WRITE, word_addr(idx_t'(base + words_in(sz) - idx_t'(1))),
          sz | word_t'($urandom_range(3)));
    cur = idx_t'(base + words_in(sz));
    for (k = 0; k < nblk; k++) begin
      sz = word_t'(8 * $urandom_range(1, 6));
      hdrs[k] = cur;
      order[k] = k;
      issue(ACT_WRITE, word_addr(cur), sz | BUSY_M | (k == 0 ? word_t'(0) : PREV_M));
      cur = idx_t'(cur + words_in(sz));
    end
    if ($urandom_range(1) == 0) begin
      issue(ACT_WRITE, word_addr(cur), END_MARK);
    end else begin
      sz = word_t'(8 * $urandom_range(1, 4));
      issue(ACT_WRITE, word_addr(cur), sz | PREV_M);
      issue(ACT_WRITE, word_addr(idx_t'(cur + words_in(sz) - idx_t'(1))), sz);
    end
    for (k = nblk - 1; k > 0; k--) begin
      j = $urandom_range(k);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    for (k = 0; k < nblk; k++) begin
      issue(ACT_FREE, payload_addr(hdrs[order[k]]), $urandom());
      if ($urandom_range(7) == 0)
        issue(ACT_FREE, payload_addr(hdrs[order[$urandom_range(k)]]), $urandom());
      if ($urandom_range(3) == 0)
        issue(ACT_READ, word_addr(hdrs[order[k]]), $urandom());
    end
  endtask

  // One item with random fields: stray writes, reads, frees of any address, unused action.
  task automatic noise_item();
    logic [ADDR_W-1:0] a;
    a = ADDR_W'($urandom());
    case ($urandom_range(9))
      0, 1, 2: issue(ACT_WRITE, a, $urandom());
      3, 4: issue(ACT_READ, a, $urandom());
      5, 6: issue(ACT_FREE, {a[ADDR_W-1:3], 3'b000}, $urandom());
      7: issue(ACT_FREE, a, $urandom());
      8: issue(ACT_FREE, '0, $urandom());
      default: issue(ACT_NONE, a, $urandom());
    endcase
  endtask

  // Receiver: a long hold-off when one is pending, otherwise random stalls.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Each result item is compared with the oldest expectation.
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: read_data %h status %0d", out_read_data, out_status);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_read_data !== want.read_data || out_status !== want.status) begin
          if (mismatches < 10)
            $display("mismatch: read_data exp %h got %h, status exp %0d got %0d",
                     want.read_data, out_read_data, want.status, out_status);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    int p;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACT_WRITE;
    in_address = '0;
    in_write_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i])
      issue(plan[i].act, plan[i].addr, plan[i].data, plan[i].typed, plan[i].want);

    // Random part in four idling phases; the first and last open with a receiver hold-off
    // while items keep coming, and each phase ends with the sender waiting for all results.
    for (p = 0; p < 4; p++) begin
      drain();
      send_idle_pct = idle_by_phase[p];
      stall_pct = stall_by_phase[p];
      if (p == 0 || p == 3) hold_left = HOLD_CYCLES;
      while (items_sent < DIRECTED_ROWS + (p + 1) * (ITEM_TARGET - DIRECTED_ROWS) / 4) begin
        if ($urandom_range(9) < 7) heap_episode();
        else repeat (4) noise_item();
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/bthf_pkg.sv
rtl/core/bthf_ram.sv
rtl/core/bthf_ctrl.sv
rtl/core/boundary_tag_heap_free.sv
sim/testbench.sv
